@@ hw/rtl/sorted_insertion_list_core_assert.svh @@
// ---------------------------------------------------------------------------
// sorted insertion list assertion macros
// shared property forms for the checker of the sorted insertion list core
// ---------------------------------------------------------------------------
`ifndef SORTED_INSERTION_LIST_CORE_ASSERT_SVH
`define SORTED_INSERTION_LIST_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define SIL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sorted insertion list check failed");

// next-cycle implication, sampled on clk, off while rst is high
`define SIL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorted insertion list check failed");

`endif

@@ hw/rtl/sil_pkg.sv @@
// ---------------------------------------------------------------------------
// sorted insertion list package
// field widths, opcode and status codes, cell control bundle
// ---------------------------------------------------------------------------
`default_nettype none

package sil_pkg;

  localparam int unsigned OPCODE_W   = 2;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned INDEX_W    = 6;
  localparam int unsigned POS_W      = 7;
  localparam int unsigned COUNT_W    = 7;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 48;

  // opcodes
  localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_READ   = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  // control broadcast to every cell
  typedef struct packed {
    logic eval;
    logic apply;
    logic descending;
  } cell_ctl_t;

endpackage

`default_nettype wire

@@ hw/rtl/sorted_insertion_list_core.sv @@
// ---------------------------------------------------------------------------
// sorted insertion list core
// sorted list of signed 32-bit values held in a row of compare/shift cells
// ---------------------------------------------------------------------------
//
//  channel   dir  payload                                   handshake
//  s_*       in   opcode, value, index  (40 bit tdata)      tvalid/tready
//  m_*       out  position, read_value, count, status (48)  tvalid/tready
//  cfg_*     in   descending (1 bit)                        write enable only
//
//  every operation steps through accept, compare in all cells and update;
//  the compare registers a stop bit in each cell and the shift pass of the
//  update follows it; a new transaction is taken the cycle after the update,
//  so no new transaction is taken before the last one is through
//  rst (synchronous) empties the list and clears the order bit
//  a result waits in the output register; if it is not taken the update
//  waits, and the input side stays stalled until it can proceed
// ---------------------------------------------------------------------------
`default_nettype none

module sorted_insertion_list_core import sil_pkg::*; #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // slave side: [1:0] opcode, [33:2] value, [39:34] index
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  // master side: [6:0] position, [38:7] read_value, [45:39] count,
  // [47:46] status
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata,
  // order register
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_wdata
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_EVAL  = 3'b010,
    S_APPLY = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  // captured transaction
  logic [OPCODE_W-1:0]       op;
  logic signed [VALUE_W-1:0] value;
  logic [INDEX_W-1:0]        index;

  logic                      descending;
  logic [CNT_W-1:0]          count;
  logic [CNT_W-1:0]          count_next;

  // read path, registered in the compare cycle
  logic signed [VALUE_W-1:0] rd_value;
  logic                      rd_ok;
  logic signed [VALUE_W-1:0] rd_mux;
  logic                      rd_in_range;

  // cell row
  cell_ctl_t                 ctl;
  logic signed [VALUE_W-1:0] cell_entry [CAPACITY];
  logic [CAPACITY-1:0]       cell_stop;
  logic [CNT_W-1:0]          slot;

  logic                      out_free;
  logic                      full;
  logic                      fire;
  logic [POS_W-1:0]          res_pos;
  logic signed [VALUE_W-1:0] res_value;
  logic [STATUS_W-1:0]       res_status;
  logic [31:0]               slot_wide;
  logic [31:0]               count_wide;

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign full     = (count == CNT_W'(CAPACITY));
  assign fire     = (state == S_APPLY) && out_free;

  assign ctl.eval       = (state == S_EVAL);
  assign ctl.apply      = fire && (op == OP_INSERT) && !full;
  assign ctl.descending = descending;

  // chain of cells, each shifting from its left neighbor on insert
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [VALUE_W-1:0] left;
    if (g == 0) begin : g_head
      assign left = cell_entry[0];
    end else begin : g_body
      assign left = cell_entry[g-1];
    end
    sil_cell #(
      .IDX   (g),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .value (value),
      .left  (left),
      .count (count),
      .slot  (slot),
      .entry (cell_entry[g]),
      .stop  (cell_stop[g])
    );
  end

  // first stopping cell, or the list end when none stops, gives the insert position
  sil_prio #(
    .N     (CAPACITY),
    .CNT_W (CNT_W)
  ) u_prio (
    .stop  (cell_stop),
    .count (count),
    .slot  (slot)
  );

  // read select across the row
  always_comb begin
    rd_in_range = (32'(index) < 32'(count)) && (32'(index) < CAPACITY);
    rd_mux      = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_mux = rd_mux | (cell_entry[i] & {VALUE_W{32'(i) == 32'(index)}});
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_EVAL;
      end
      S_EVAL: begin
        state_next = S_APPLY;
      end
      S_APPLY: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // result and count update
  always_comb begin
    count_next = count;
    res_pos    = '0;
    res_value  = '0;
    res_status = ST_OK;
    slot_wide  = 32'(slot);
    unique case (op)
      OP_INSERT: begin
        if (full) begin
          res_status = ST_FULL;
        end else begin
          count_next = count + CNT_W'(1);
          res_pos    = slot_wide[POS_W-1:0];
        end
      end
      OP_READ: begin
        if (rd_ok) begin
          res_value = rd_value;
        end else begin
          res_status = ST_RANGE;
        end
      end
      OP_CLEAR: begin
        count_next = '0;
      end
      default: begin
        // unused opcode: nothing changes
      end
    endcase
    count_wide = 32'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      descending <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        descending <= cfg_wdata;
      end
      if (fire) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op    <= s_tdata[1:0];
      value <= s_tdata[33:2];
      index <= s_tdata[39:34];
    end
    if (state == S_EVAL) begin
      rd_value <= rd_mux;
      rd_ok    <= rd_in_range;
    end
    if (fire) begin
      m_tdata <= {res_status, count_wide[COUNT_W-1:0], res_value, res_pos};
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/sil_cell.sv @@
// ---------------------------------------------------------------------------
// sorted insertion list cell
// one list slot: order compare against the broadcast value, shift from left
// ---------------------------------------------------------------------------
`default_nettype none

module sil_cell import sil_pkg::*; #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CNT_W = 7
) (
  input  wire logic                      clk,
  input  wire cell_ctl_t                 ctl,
  input  wire logic signed [VALUE_W-1:0] value,
  input  wire logic signed [VALUE_W-1:0] left,
  input  wire logic [CNT_W-1:0]          count,
  input  wire logic [CNT_W-1:0]          slot,
  output logic signed [VALUE_W-1:0]      entry,
  output logic                           stop
);

  localparam logic [CNT_W-1:0] MY_POS = CNT_W'(IDX);

  logic occupied;
  logic hit;

  always_comb begin
    occupied = MY_POS < count;
    hit      = occupied & (ctl.descending ? (entry <= value) : (entry > value));
  end

  always_ff @(posedge clk) begin
    if (ctl.eval) begin
      stop <= hit;
    end
    if (ctl.apply) begin
      if (MY_POS == slot) begin
        entry <= value;
      end else if ((MY_POS > slot) && (MY_POS <= count)) begin
        entry <= left;
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/sil_prio.sv @@
// ---------------------------------------------------------------------------
// sorted insertion list slot finder
// first stopping cell wins, the list end when no cell stops
// ---------------------------------------------------------------------------
`default_nettype none

module sil_prio import sil_pkg::*; #(
  parameter int unsigned N     = 64,
  parameter int unsigned CNT_W = 7
) (
  input  wire logic [N-1:0]     stop,
  input  wire logic [CNT_W-1:0] count,
  output logic [CNT_W-1:0]      slot
);

  logic [N-1:0]     first;
  logic [CNT_W-1:0] enc;

  always_comb begin
    // isolate lowest set bit
    first = stop & (~stop + N'(1));
    enc   = '0;
    for (int i = 0; i < N; i++) begin
      enc = enc | (first[i] ? CNT_W'(i) : '0);
    end
    slot = (|stop) ? enc : count;
  end

endmodule

`default_nettype wire

@@ hw/rtl/sil_checker.sv @@
// ---------------------------------------------------------------------------
// sorted insertion list checker
// port-level properties of the result stream, bound to the core
// ---------------------------------------------------------------------------
`default_nettype none

`include "sorted_insertion_list_core_assert.svh"

module sil_checker import sil_pkg::*; #(
  parameter int unsigned CAPACITY = 64
) (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  m_tvalid,
  input wire logic                  m_tready,
  input wire logic [OUT_DATA_W-1:0] m_tdata
);

  logic [POS_W-1:0]    pos;
  logic [VALUE_W-1:0]  rdv;
  logic [COUNT_W-1:0]  cnt;
  logic [STATUS_W-1:0] sts;

  assign pos = m_tdata[6:0];
  assign rdv = m_tdata[38:7];
  assign cnt = m_tdata[45:39];
  assign sts = m_tdata[47:46];

  // a refused insert reports no position and no data
  `SIL_ASSERT_IMP(a_full_quiet, m_tvalid && (sts == ST_FULL), (pos == '0) && (rdv == '0))
  // a read out of range returns zero and no position
  `SIL_ASSERT_IMP(a_range_quiet, m_tvalid && (sts == ST_RANGE), (pos == '0) && (rdv == '0))
  // count never passes the capacity (only checkable below the 7-bit wrap)
  `SIL_ASSERT_IMP(a_count_cap, m_tvalid && (CAPACITY < 128), 32'(cnt) <= CAPACITY)
  // a stalled result holds
  `SIL_ASSERT_NXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind sorted_insertion_list_core sil_checker #(
  .CAPACITY (CAPACITY)
) u_sil_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

@@ dv/sorted_insertion_list_core_tb.sv @@
// ---------------------------------------------------------------------------
// sorted insertion list core testbench
// drives insert, read, clear and unused-opcode transactions into the core,
// tracks the list contents in a scoreboard and checks every result field
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module sorted_insertion_list_core_tb;
  import sil_pkg::*;

  localparam int unsigned CAP          = 64;
  localparam int unsigned RANDOM_ITEMS = 1850;
  localparam int unsigned MAX_PRINTED  = 40;

  // opcode 3 is not in the package: the core must treat it as a no-op
  localparam logic [OPCODE_W-1:0] OP_NOP = 2'd3;

  // request transaction, lowest field last
  typedef struct packed {
    logic [INDEX_W-1:0]  index;
    logic [VALUE_W-1:0]  value;
    logic [OPCODE_W-1:0] opcode;
  } request_t;

  // result transaction, lowest field last
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
    logic [VALUE_W-1:0]  read_value;
    logic [POS_W-1:0]    position;
  } answer_t;

  // -------------------------------------------------------------------------
  // scoreboard: own copy of the list, order bit and the answers still owed
  // -------------------------------------------------------------------------
  class sorted_list_tracker;
    logic signed [VALUE_W-1:0] slots [CAP];
    int unsigned               fill;
    bit                        descending;
    answer_t                   pending_answers [$];
    int unsigned               mismatches;

    task report(string msg);
      if (mismatches < MAX_PRINTED) begin
        $display("%0t ns  mismatch: %s", $time, msg);
      end
      mismatches++;
    endtask

    // first slot that breaks the order condition, scanning from the head
    function int unsigned landing_slot(logic signed [VALUE_W-1:0] v);
      int unsigned i;
      for (i = 0; i < fill; i++) begin
        if (descending ? (slots[i] <= v) : (slots[i] > v)) begin
          break;
        end
      end
      return i;
    endfunction

    function void take_request(request_t r);
      answer_t     a;
      int unsigned at;
      int unsigned k;
      a = '0;
      a.status = ST_OK;
      case (r.opcode)
        OP_INSERT: begin
          if (fill >= CAP) begin
            a.status = ST_FULL;
          end else begin
            at = landing_slot(r.value);
            for (k = fill; k > at; k--) begin
              slots[k] = slots[k-1];
            end
            slots[at] = r.value;
            fill++;
            a.position = at[POS_W-1:0];
          end
        end
        OP_READ: begin
          if (r.index < fill) begin
            a.read_value = slots[r.index];
          end else begin
            a.status = ST_RANGE;
          end
        end
        OP_CLEAR: begin
          fill = 0;
        end
        default: begin
        end
      endcase
      a.count = fill[COUNT_W-1:0];
      pending_answers.push_back(a);
    endfunction

    task check_result(answer_t got);
      answer_t e;
      if (pending_answers.size() == 0) begin
        report($sformatf("result %h with nothing outstanding", got));
        return;
      end
      e = pending_answers.pop_front();
      if (got.position !== e.position) begin
        report($sformatf("position %0d, want %0d", got.position, e.position));
      end
      if (got.read_value !== e.read_value) begin
        report($sformatf("read_value %h, want %h", got.read_value, e.read_value));
      end
      if (got.count !== e.count) begin
        report($sformatf("count %0d, want %0d", got.count, e.count));
      end
      if (got.status !== e.status) begin
        report($sformatf("status %0d, want %0d", got.status, e.status));
      end
    endtask
  endclass

  // -------------------------------------------------------------------------
  // clock, reset and block hookup
  // -------------------------------------------------------------------------
  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;   // [1:0] opcode, [33:2] value, [39:34] index
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;   // [6:0] position, [38:7] read_value,
                                    // [45:39] count, [47:46] status
  logic                  cfg_we;
  logic                  cfg_wdata;

  sorted_list_tracker tracker = new();

  int unsigned burst_left;    // transactions left in the current sender burst
  int unsigned rx_tick;       // free-running count for the periodic stall mode

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  sorted_insertion_list_core #(
    .CAPACITY (CAP)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // -------------------------------------------------------------------------
  // monitors: both channels sampled at the rising edge
  // a result is registered, so it never belongs to a request taken the
  // same edge; checking first keeps that obvious
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      tracker.check_result(answer_t'(m_tdata));
    end
    if (!rst && s_tvalid && s_tready) begin
      tracker.take_request(request_t'(s_tdata));
    end
  end

  // -------------------------------------------------------------------------
  // receiver: stall pattern switches at random between four modes
  //   0 always ready, 1 coin toss, 2 one stall in three, 3 mostly stalled
  // -------------------------------------------------------------------------
  initial begin
    int unsigned rx_mode;
    int unsigned span;
    m_tready = 1'b0;
    rx_tick  = 0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      rx_mode = $urandom_range(0, 3);
      span    = $urandom_range(20, 200);
      repeat (span) begin
        @(negedge clk);
        rx_tick++;
        case (rx_mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= (rx_tick % 3 != 0);
          default: m_tready <= ($urandom_range(0, 5) == 0);
        endcase
      end
    end
  end

  // -------------------------------------------------------------------------
  // sender tasks, all entered and left at a falling edge
  // -------------------------------------------------------------------------

  // one request transaction; returns at the falling edge after acceptance
  task automatic drive_request(logic [OPCODE_W-1:0] op, logic [VALUE_W-1:0] v,
                               logic [INDEX_W-1:0] idx);
    request_t r;
    r.opcode = op;
    r.value  = v;
    r.index  = idx;
    s_tvalid <= 1'b1;
    s_tdata  <= r;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // bursts of random length with random gaps; now and then a long
  // stretch with no gap at all
  task automatic push_op(logic [OPCODE_W-1:0] op, logic [VALUE_W-1:0] v,
                         logic [INDEX_W-1:0] idx);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    drive_request(op, v, idx);
  endtask

  // hold the sender off until every outstanding result has come back
  task automatic drain_results();
    s_tvalid <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (tracker.pending_answers.size() != 0);
  endtask

  // order bit write, only with the core idle
  task automatic write_order(bit d);
    drain_results();
    repeat (4) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= d;
    @(negedge clk);
    cfg_we    <= 1'b0;
    tracker.descending = d;
  endtask

  // values: many small ones so equal entries pile up, some extremes
  function automatic logic [VALUE_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) begin
      return $urandom_range(0, 8) - 4;
    end
    if (r == 4) begin
      case ($urandom_range(0, 3))
        0: return 32'h8000_0000;
        1: return 32'h7fff_ffff;
        2: return 32'h0000_0000;
        default: return 32'hffff_ffff;
      endcase
    end
    return $urandom;
  endfunction

  // indexes: mostly inside the list or just past its end
  function automatic logic [INDEX_W-1:0] pick_index();
    if (tracker.fill == 0 || $urandom_range(0, 4) == 0) begin
      return INDEX_W'($urandom_range(0, 63));
    end
    return INDEX_W'($urandom_range(0, (tracker.fill > 63) ? 63 : tracker.fill));
  endfunction

  // -------------------------------------------------------------------------
  // main sequence
  // -------------------------------------------------------------------------
  initial begin
    int unsigned random_sent;
    int unsigned phase_no;
    int unsigned phase_len;
    int unsigned n;
    int unsigned r;
    bit          climb_only;
    bit          mid_drain;
    logic [OPCODE_W-1:0] op;

    s_tvalid   = 1'b0;
    s_tdata    = '0;
    cfg_we     = 1'b0;
    cfg_wdata  = 1'b0;
    rst        = 1'b1;
    burst_left = 0;
    random_sent = 0;
    phase_no    = 0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed, ascending: empty read, extremes, duplicates, range edges
    write_order(1'b0);
    push_op(OP_READ,   32'h0,         6'd0);    // read on an empty list
    push_op(OP_INSERT, 32'h0000_0000, 6'd0);
    push_op(OP_INSERT, 32'h7fff_ffff, 6'd0);
    push_op(OP_INSERT, 32'h8000_0000, 6'd0);
    push_op(OP_INSERT, 32'h0000_0000, 6'd0);    // lands after the equal entry
    push_op(OP_INSERT, 32'hffff_ffff, 6'd0);
    push_op(OP_INSERT, 32'h0000_0001, 6'd0);
    push_op(OP_READ,   32'h0,         6'd0);
    push_op(OP_READ,   32'h0,         6'd5);    // last valid entry
    push_op(OP_READ,   32'h0,         6'd6);    // first index past the count
    push_op(OP_READ,   32'h0,         6'd63);
    push_op(OP_NOP,    32'hffff_ffff, 6'd63);   // unused opcode, all ones
    push_op(OP_CLEAR,  32'h0,         6'd0);
    push_op(OP_READ,   32'h0,         6'd0);    // nothing left after clear

    // directed, descending: equal values land ahead of existing ones
    write_order(1'b1);
    push_op(OP_INSERT, 32'h0000_0005, 6'd0);
    push_op(OP_INSERT, 32'h7fff_ffff, 6'd0);
    push_op(OP_INSERT, 32'h8000_0000, 6'd0);
    push_op(OP_INSERT, 32'h0000_0005, 6'd0);
    push_op(OP_READ,   32'h0,         6'd1);
    push_op(OP_READ,   32'h0,         6'd3);

    // order flipped back without a clear: the list stays as it is
    write_order(1'b0);
    push_op(OP_INSERT, 32'h0000_0006, 6'd0);
    push_op(OP_READ,   32'h0,         6'd0);
    push_op(OP_CLEAR,  32'h0,         6'd0);

    // random phases: each one idles the core, sets the order bit and
    // mostly starts from an empty list; climbing phases issue no clear
    // after that, so the list fills up and inserts get refused
    while (random_sent < RANDOM_ITEMS) begin
      phase_len  = $urandom_range(60, 250);
      climb_only = ($urandom_range(0, 2) == 0);
      mid_drain  = (phase_no == 0) || ($urandom_range(0, 3) == 0);
      write_order((phase_no % 3 == 2) ? 1'($urandom_range(0, 1)) : !phase_no[0]);
      if ($urandom_range(0, 2) != 0) begin
        push_op(OP_CLEAR, $urandom, INDEX_W'($urandom_range(0, 63)));
        random_sent++;
      end
      for (n = 0; n < phase_len; n++) begin
        if (mid_drain && n == phase_len / 2) begin
          drain_results();
        end
        r = $urandom_range(0, 99);
        if (climb_only) begin
          op = (r < 75) ? OP_INSERT : (r < 97) ? OP_READ : OP_NOP;
        end else begin
          op = (r < 50) ? OP_INSERT : (r < 90) ? OP_READ
             : (r < 94) ? OP_CLEAR : OP_NOP;
        end
        push_op(op, pick_value(), pick_index());
        random_sent++;
      end
      phase_no++;
    end

    // wind down: every result back, then a wait for stray outputs
    drain_results();
    repeat (10) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending_answers.size() == 0) begin
      $display("sorted_insertion_list_core_tb OK");
    end else begin
      $display("sorted_insertion_list_core_tb NOT OK");
    end
    $finish;
  end

  // hard stop well past the slowest legal run
  initial begin
    #(4_000_000);
    $display("sorted_insertion_list_core_tb NOT OK");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/sil_pkg.sv
hw/rtl/sil_cell.sv
hw/rtl/sil_prio.sv
hw/rtl/sorted_insertion_list_core.sv
hw/rtl/sil_checker.sv
dv/sorted_insertion_list_core_tb.sv
